FILE: src/lpws_pkg.sv
// Package for the LED pulse-width data sender.
// Types, timing constants and codes shared by the payload, sender and top files.
`default_nettype none

package lpws_pkg;

    // Shift store depth (2 to 8 bytes)
    localparam int PAYLOAD_BYTES = 5;
    localparam int PAY_MAX       = 8;
    localparam int SHIFT_ADDR_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam int TICK_W     = 8;
    localparam int BIT_NUM_W  = 6;
    localparam int BYTE_IDX_W = 3;
    localparam int PEND_W     = 5;
    localparam int DIGIT_W    = 4;
    localparam int SECS_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 4;

    // Tick-count timing
    localparam int LOW_TICKS    = 4;
    localparam int PREAMBLE_END = 64;
    localparam int ZERO_END     = 4 + 4;
    localparam int ONE_END      = 4 + 12;
    localparam int TRAILER_END  = 28 + 4;

    // Frame lengths in bits and bytes loaded at capture
    localparam int VERSION_BITS  = 10;
    localparam int SECONDS_BITS  = 40;
    localparam int VERSION_BYTES = VERSION_BITS / 8 + 1;
    localparam int SECONDS_BYTES = SECONDS_BITS / 8 + 1;

    typedef enum logic [1:0] {
        OP_IDLE        = 2'd0,
        OP_VERSION     = 2'd1,
        OP_SECONDS     = 2'd2,
        OP_SECONDS_ALT = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH = 2'd2;

    typedef struct packed {
        logic [DIGIT_W-1:0] major;
        logic [DIGIT_W-1:0] minor;
        logic [DIGIT_W-1:0] patch;
    } digits_t;

    typedef struct packed {
        logic                    long_frame;
        logic [PAY_MAX-1:0][7:0] bytes;
    } payload_t;

    typedef struct packed {
        logic led_level;
        logic led_driven;
    } result_t;

endpackage

`default_nettype wire

FILE: src/lpws_payload.sv
// Payload builder: version byte pair or seconds bytes with byte-sum checksum.
// Depends on lpws_pkg.
`default_nettype none

module lpws_payload (
    input  wire lpws_pkg::op_t                    op,
    input  wire logic [lpws_pkg::SECS_W-1:0]      filter_seconds,
    input  wire lpws_pkg::digits_t                digits,
    output lpws_pkg::payload_t                    payload
);

    logic [7:0] ver_packed;
    logic [7:0] ver_sum;
    logic [7:0] secs_sum;

    always_comb begin
        ver_packed = ({4'b0, digits.major} << 6) | ({4'b0, digits.minor} << 3)
                   | {4'b0, digits.patch};
        ver_sum    = {4'b0, digits.major} + {4'b0, digits.minor} + {4'b0, digits.patch};
        secs_sum   = filter_seconds[7:0] + filter_seconds[15:8]
                   + filter_seconds[23:16] + filter_seconds[31:24];

        payload = '0;
        if (op == lpws_pkg::OP_VERSION) begin
            payload.long_frame = 1'b0;
            payload.bytes[0]   = ver_packed;
            payload.bytes[1]   = ver_sum;
        end else begin
            payload.long_frame = 1'b1;
            payload.bytes[0]   = filter_seconds[7:0];
            payload.bytes[1]   = filter_seconds[15:8];
            payload.bytes[2]   = filter_seconds[23:16];
            payload.bytes[3]   = filter_seconds[31:24];
            payload.bytes[4]   = secs_sum;
        end
    end

endmodule

`default_nettype wire

FILE: src/lpws_sender.sv
// Frame sequencer: tick counter, bit counter, byte shift store and LED level.
// Depends on lpws_pkg; advances one tick per step while the opcode is not idle.
`default_nettype none

module lpws_sender (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire lpws_pkg::op_t        op,
    input  wire lpws_pkg::payload_t   payload,
    output lpws_pkg::result_t         result
);

    logic [lpws_pkg::TICK_W-1:0]     tick_reg, tick_next;
    logic [lpws_pkg::BIT_NUM_W-1:0]  bit_reg, bit_next;
    logic [lpws_pkg::BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic [lpws_pkg::PEND_W-1:0]     pend_reg, pend_next;
    logic                            held_reg, held_next;
    logic [lpws_pkg::PAYLOAD_BYTES-1:0][7:0] shift_reg, shift_next;

    logic [lpws_pkg::TICK_W-1:0]       tick_inc;
    logic                              in_range;
    logic [lpws_pkg::SHIFT_ADDR_W-1:0] sel;
    logic [7:0]                        cur_byte;
    logic [lpws_pkg::BIT_NUM_W-1:0]    frame_bits;
    logic [lpws_pkg::CNT_W-1:0]        cap_count;
    logic [lpws_pkg::PEND_W-1:0]       pend_v;
    logic                              led;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            bit_reg  <= '0;
            idx_reg  <= '0;
            pend_reg <= '0;
            held_reg <= 1'b0;
        end else begin
            tick_reg <= tick_next;
            bit_reg  <= bit_next;
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

    // Shift store holds nothing meaningful until the first capture
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    always_comb begin
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        held_next  = held_reg;
        shift_next = shift_reg;
        led        = held_reg;
        pend_v     = pend_reg;

        tick_inc   = tick_reg + 8'd1;
        in_range   = {1'b0, idx_reg} < lpws_pkg::CNT_W'(lpws_pkg::PAYLOAD_BYTES);
        sel        = idx_reg[lpws_pkg::SHIFT_ADDR_W-1:0];
        cur_byte   = in_range ? shift_reg[sel] : 8'd0;
        frame_bits = payload.long_frame ? lpws_pkg::BIT_NUM_W'(lpws_pkg::SECONDS_BITS)
                                        : lpws_pkg::BIT_NUM_W'(lpws_pkg::VERSION_BITS);
        cap_count  = payload.long_frame ? lpws_pkg::CNT_W'(lpws_pkg::SECONDS_BYTES)
                                        : lpws_pkg::CNT_W'(lpws_pkg::VERSION_BYTES);

        if (step && op != lpws_pkg::OP_IDLE) begin
            tick_next = tick_inc;
            if (tick_inc < lpws_pkg::TICK_W'(lpws_pkg::LOW_TICKS)) begin
                led = 1'b0;
            end else begin
                led = 1'b1;
                if (bit_reg == '0) begin
                    // preamble done: load payload, start bit 1
                    if (tick_inc >= lpws_pkg::TICK_W'(lpws_pkg::PREAMBLE_END)) begin
                        for (int i = 0; i < lpws_pkg::PAYLOAD_BYTES; i++) begin
                            if (lpws_pkg::CNT_W'(i) < cap_count) begin
                                shift_next[i] = payload.bytes[i];
                            end
                        end
                        led       = 1'b0;
                        tick_next = '0;
                        bit_next  = lpws_pkg::BIT_NUM_W'(1);
                        idx_next  = '0;
                    end
                end else if (bit_reg <= frame_bits) begin
                    if (tick_inc == lpws_pkg::TICK_W'(lpws_pkg::LOW_TICKS)) begin
                        pend_v = cur_byte[0] ? lpws_pkg::PEND_W'(lpws_pkg::ONE_END)
                                             : lpws_pkg::PEND_W'(lpws_pkg::ZERO_END);
                        if (in_range) begin
                            shift_next[sel] = cur_byte >> 1;
                        end
                    end
                    pend_next = pend_v;
                    if ({3'b0, pend_v} == tick_inc) begin
                        if (bit_reg[2:0] == 3'd0) begin
                            idx_next = idx_reg + 3'd1;
                        end
                        led       = 1'b0;
                        tick_next = '0;
                        bit_next  = bit_reg + 6'd1;
                    end
                end else if (tick_inc >= lpws_pkg::TICK_W'(lpws_pkg::TRAILER_END)) begin
                    led       = 1'b0;
                    tick_next = '0;
                    bit_next  = '0;
                end
            end
            held_next = led;
        end

        result.led_level  = led;
        result.led_driven = (op != lpws_pkg::OP_IDLE);
    end

endmodule

`default_nettype wire

FILE: src/led_pulse_width_data_sender_core.sv
// Top level of the LED pulse-width data sender: config registers, input and result registers.
// Depends on lpws_pkg, lpws_payload and lpws_sender.
`default_nettype none

// One input transfer is one timer tick; each yields exactly one result transfer.
// A tick is taken every cycle when the result side keeps up; each tick passes
// through the input register and the result register around the frame
// sequencer. Opcode 0 leaves all state alone and reports the held LED level with
// led_driven low. Digit registers are written through the cfg channel, which is
// ready whenever reset is released; index 3 is ignored.
module led_pulse_width_data_sender_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire logic [1:0]                          s_opcode,
    input  wire logic [lpws_pkg::SECS_W-1:0]         s_filter_seconds,
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      logic                                m_led_level,
    output      logic                                m_led_driven,
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [lpws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lpws_pkg::DIGIT_W-1:0]        cfg_data
);

    lpws_pkg::digits_t               digits_reg, digits_next;
    logic                            in_valid_reg, in_valid_next;
    lpws_pkg::op_t                   in_op_reg;
    logic [lpws_pkg::SECS_W-1:0]     in_secs_reg;
    logic                            out_valid_reg, out_valid_next;
    lpws_pkg::result_t               out_res_reg;

    logic                s_fire;
    logic                advance;
    lpws_pkg::payload_t  payload;
    lpws_pkg::result_t   result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = aresetn && (!in_valid_reg || advance);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = aresetn;

    always_comb begin
        digits_next = digits_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lpws_pkg::CFG_MAJOR: digits_next.major = cfg_data;
                lpws_pkg::CFG_MINOR: digits_next.minor = cfg_data;
                lpws_pkg::CFG_PATCH: digits_next.patch = cfg_data;
                default:             digits_next = digits_reg;
            endcase
        end
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : ((m_valid && m_ready) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg.major <= lpws_pkg::DIGIT_W'(1);
            digits_reg.minor <= '0;
            digits_reg.patch <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            digits_reg    <= digits_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg   <= lpws_pkg::op_t'(s_opcode);
            in_secs_reg <= s_filter_seconds;
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    lpws_payload u_payload (
        .op             (in_op_reg),
        .filter_seconds (in_secs_reg),
        .digits         (digits_reg),
        .payload        (payload)
    );

    lpws_sender u_sender (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .op      (in_op_reg),
        .payload (payload),
        .result  (result)
    );

    assign m_valid      = out_valid_reg;
    assign m_led_level  = out_res_reg.led_level;
    assign m_led_driven = out_res_reg.led_driven;

`ifndef NO_ASSERTIONS
    a_advance_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("tick left the input register without producing a result");

    a_idle_not_driven: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == lpws_pkg::OP_IDLE) |=> !m_led_driven)
        else $error("idle tick reported a driven LED");

    a_busy_driven: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg != lpws_pkg::OP_IDLE) |=> m_led_driven)
        else $error("active tick reported an undriven LED");

    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> in_valid_reg)
        else $error("accepted transfer not held in the input register");
`endif

endmodule

`default_nettype wire

FILE: test/led_pulse_width_data_sender_core_tb.sv
// Testbench for led_pulse_width_data_sender_core: drives timer ticks and digit writes,
// predicts each LED result in lockstep and checks every result transfer. Uses lpws_pkg.
`default_nettype none

module led_pulse_width_data_sender_core_tb;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_opcode = lpws_pkg::OP_IDLE;
    logic [lpws_pkg::SECS_W-1:0]     s_filter_seconds = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_led_level;
    logic                            m_led_driven;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lpws_pkg::CFG_IDX_W-1:0]  cfg_index = lpws_pkg::CFG_MAJOR;
    logic [lpws_pkg::DIGIT_W-1:0]    cfg_data = '0;

    led_pulse_width_data_sender_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_filter_seconds (s_filter_seconds),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_led_level      (m_led_level),
        .m_led_driven     (m_led_driven),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Frame sequencer mirror
    lpws_pkg::digits_t                     digits_q;
    logic [lpws_pkg::TICK_W-1:0]           tick_q;
    logic [lpws_pkg::BIT_NUM_W-1:0]        bit_q;
    logic [lpws_pkg::BYTE_IDX_W-1:0]       byte_q;
    logic [7:0]                            shift_q [lpws_pkg::PAYLOAD_BYTES];
    logic [lpws_pkg::PEND_W-1:0]           pend_q;
    logic                                  led_q;
    logic [lpws_pkg::PAYLOAD_BYTES-1:0]    loaded_q;

    lpws_pkg::result_t pending_leds [$];
    int                mismatch_count = 0;
    int                burst_left = 0;

    function automatic lpws_pkg::result_t led_frame_step(input lpws_pkg::op_t op,
                                                         input logic [lpws_pkg::SECS_W-1:0] secs);
        lpws_pkg::result_t r;
        logic [7:0]        pay [lpws_pkg::PAY_MAX];
        int                nbits;
        int                count;
        int                packed_digits;
        logic [7:0]        b;
        logic              led;
        r.led_level  = led_q;
        r.led_driven = 1'b0;
        if (op == lpws_pkg::OP_IDLE)
            return r;
        for (int i = 0; i < lpws_pkg::PAY_MAX; i++)
            pay[i] = 8'h00;
        if (op == lpws_pkg::OP_VERSION) begin
            packed_digits = int'(digits_q.patch) | (int'(digits_q.minor) << 3)
                          | (int'(digits_q.major) << 6);
            pay[0] = packed_digits[7:0];
            pay[1] = 8'(int'(digits_q.patch) + int'(digits_q.minor) + int'(digits_q.major));
            nbits  = lpws_pkg::VERSION_BITS;
        end else begin
            pay[0] = secs[7:0];
            pay[1] = secs[15:8];
            pay[2] = secs[23:16];
            pay[3] = secs[31:24];
            pay[4] = pay[0] + pay[1] + pay[2] + pay[3];
            nbits  = lpws_pkg::SECONDS_BITS;
        end
        tick_q = tick_q + 8'd1;
        if (tick_q < lpws_pkg::LOW_TICKS) begin
            led = 1'b0;
        end else begin
            led = 1'b1;
            if (bit_q == 0) begin
                if (tick_q >= lpws_pkg::PREAMBLE_END) begin
                    count = nbits / 8 + 1;
                    if (count > lpws_pkg::PAYLOAD_BYTES)
                        count = lpws_pkg::PAYLOAD_BYTES;
                    for (int i = 0; i < count; i++) begin
                        shift_q[i]  = pay[i];
                        loaded_q[i] = 1'b1;
                    end
                    led    = 1'b0;
                    tick_q = '0;
                    bit_q  = lpws_pkg::BIT_NUM_W'(1);
                    byte_q = '0;
                end
            end else if (bit_q <= nbits) begin
                if (tick_q == lpws_pkg::LOW_TICKS) begin
                    b = 8'h00;
                    if (byte_q < lpws_pkg::PAYLOAD_BYTES)
                        b = shift_q[byte_q];
                    pend_q = b[0] ? lpws_pkg::PEND_W'(lpws_pkg::ONE_END)
                                  : lpws_pkg::PEND_W'(lpws_pkg::ZERO_END);
                    if (byte_q < lpws_pkg::PAYLOAD_BYTES)
                        shift_q[byte_q] = b >> 1;
                end
                if (lpws_pkg::TICK_W'(pend_q) == tick_q) begin
                    if (bit_q[2:0] == 3'd0)
                        byte_q = byte_q + 3'd1;
                    led    = 1'b0;
                    tick_q = '0;
                    bit_q  = bit_q + 6'd1;
                end
            end else if (tick_q >= lpws_pkg::TRAILER_END) begin
                led    = 1'b0;
                tick_q = '0;
                bit_q  = '0;
            end
        end
        led_q        = led;
        r.led_level  = led;
        r.led_driven = 1'b1;
        return r;
    endfunction

    // A seconds frame switched in mid-frame would read shift bytes a version capture
    // never loaded, until a seconds capture has filled the whole store.
    function automatic lpws_pkg::op_t loaded_safe_op(input lpws_pkg::op_t op);
        if (op != lpws_pkg::OP_IDLE && op != lpws_pkg::OP_VERSION && !(&loaded_q) && bit_q != 0)
            return lpws_pkg::OP_VERSION;
        return op;
    endfunction

    function automatic int sender_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            burst_left = $urandom_range(50, 200);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [lpws_pkg::SECS_W-1:0] pick_seconds();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return '1;
            2: return lpws_pkg::SECS_W'(1) << $urandom_range(0, lpws_pkg::SECS_W - 1);
            3: return ~(lpws_pkg::SECS_W'(1) << $urandom_range(0, lpws_pkg::SECS_W - 1));
            default: return $urandom;
        endcase
    endfunction

    // One tick transfer; valid stays high into the next call when there is no gap
    task automatic send_tick(input lpws_pkg::op_t op, input logic [lpws_pkg::SECS_W-1:0] secs);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_filter_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        pending_leds.push_back(led_frame_step(op, secs));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_leds.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_digits(input int major, input int minor, input int patch);
        logic [lpws_pkg::CFG_IDX_W-1:0] idx [3];
        int                             val [3];
        idx = '{lpws_pkg::CFG_MAJOR, lpws_pkg::CFG_MINOR, lpws_pkg::CFG_PATCH};
        val = '{major, minor, patch};
        wait_idle();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= lpws_pkg::DIGIT_W'(val[i]);
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                lpws_pkg::CFG_MAJOR: digits_q.major = lpws_pkg::DIGIT_W'(val[i]);
                lpws_pkg::CFG_MINOR: digits_q.minor = lpws_pkg::DIGIT_W'(val[i]);
                default:             digits_q.patch = lpws_pkg::DIGIT_W'(val[i]);
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Frames follow one opcode; switch_pct injects opcode changes mid-frame
    task automatic run_ticks(input int n, input int seconds_pct, input int switch_pct);
        lpws_pkg::op_t frame_op;
        lpws_pkg::op_t op;
        int            sent;
        int            r;
        frame_op = lpws_pkg::OP_VERSION;
        sent     = 0;
        while (sent < n) begin
            if (bit_q == 0 && tick_q == 0) begin
                if ($urandom_range(0, 99) < seconds_pct)
                    frame_op = $urandom_range(0, 1) ? lpws_pkg::OP_SECONDS
                                                    : lpws_pkg::OP_SECONDS_ALT;
                else
                    frame_op = lpws_pkg::OP_VERSION;
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                op = lpws_pkg::OP_IDLE;
            else if (r < 8 + switch_pct)
                op = lpws_pkg::op_t'($urandom_range(1, 3));
            else
                op = frame_op;
            op = loaded_safe_op(op);
            send_tick(op, pick_seconds());
            if (op != lpws_pkg::OP_IDLE)
                sent++;
        end
    endtask

    task automatic test_directed();
        send_tick(lpws_pkg::OP_IDLE, '0);
        send_tick(lpws_pkg::OP_IDLE, '1);
        send_tick(lpws_pkg::OP_SECONDS_ALT, '1);
        send_tick(lpws_pkg::OP_SECONDS, '0);
        send_tick(lpws_pkg::OP_IDLE, 32'h0000_FFFF);
        send_tick(lpws_pkg::OP_VERSION, 32'h8000_0000);
        send_tick(lpws_pkg::OP_SECONDS, 32'h0000_0001);
        send_tick(lpws_pkg::OP_SECONDS_ALT, 32'h5A5A_A5A5);
        send_tick(lpws_pkg::OP_IDLE, 32'hA5A5_5A5A);
        send_tick(lpws_pkg::OP_VERSION, '1);
        send_tick(lpws_pkg::OP_IDLE, '0);
        send_tick(lpws_pkg::OP_SECONDS, 32'hFFFF_0000);
        send_tick(lpws_pkg::OP_VERSION, '0);
        send_tick(lpws_pkg::OP_SECONDS_ALT, 32'h7FFF_FFFF);
        send_tick(lpws_pkg::OP_IDLE, '1);
        send_tick(lpws_pkg::OP_VERSION, 32'h1234_5678);
    endtask

    task automatic test_reset_digits();
        run_ticks(200, 0, 0);
    endtask

    task automatic test_max_digits();
        write_digits(9, 9, 9);
        run_ticks(200, 10, 3);
    endtask

    task automatic test_seconds_frames();
        write_digits(0, 0, 0);
        run_ticks(450, 90, 2);
    endtask

    task automatic test_opcode_switch();
        write_digits($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 9));
        run_ticks(250, 50, 15);
    endtask

    always @(posedge aclk) begin
        lpws_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_leds.size() == 0) begin
                $display("%0t: result with nothing expected: level=%0b driven=%0b",
                         $time, m_led_level, m_led_driven);
                mismatch_count++;
            end else begin
                want = pending_leds.pop_front();
                if (m_led_level !== want.led_level) begin
                    $display("%0t: led_level expected %0b actual %0b",
                             $time, want.led_level, m_led_level);
                    mismatch_count++;
                end
                if (m_led_driven !== want.led_driven) begin
                    $display("%0t: led_driven expected %0b actual %0b",
                             $time, want.led_driven, m_led_driven);
                    mismatch_count++;
                end
            end
        end
    end

    // Result side backpressure, with long stretches of steady ready
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 300)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            m_ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    end

    initial begin
        digits_q.major = 4'd1;
        digits_q.minor = 4'd0;
        digits_q.patch = 4'd0;
        tick_q   = '0;
        bit_q    = '0;
        byte_q   = '0;
        pend_q   = '0;
        led_q    = 1'b0;
        loaded_q = '0;
        for (int i = 0; i < lpws_pkg::PAYLOAD_BYTES; i++)
            shift_q[i] = 8'h00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_reset_digits();
        test_max_digits();
        test_seconds_frames();
        test_opcode_switch();

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
